[sv/tacc_pkg.sv]
`timescale 1ns / 1ps

package tacc_pkg;

  // command codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_SET   = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_EVENT = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam logic [TICK_W-1:0] PERIOD_TOP_RST = 16'hFFFF;

  // alarm bookkeeping kept between beats
  typedef struct packed {
    logic [TICK_W-1:0] alarm_value;
    logic              armed;
    logic              update_held;
    logic              write_in_flight;
    logic [TICK_W-1:0] wrap_count;
  } state_t;

  // one input beat, unpacked
  typedef struct packed {
    logic [2:0]        mode;
    logic [TICK_W-1:0] alarm_time;
    logic              compare_written;
    logic              reload_match;
    logic              compare_match;
    logic [TICK_W-1:0] counter_low;
  } item_t;

  // one result beat
  typedef struct packed {
    logic              write_compare;
    logic [TICK_W-1:0] compare_value;
    logic              fire_handler;
    logic [TIME_W-1:0] time_extended;
    logic              alarm_is_active;
    logic              stop_must_wait;
  } result_t;

endpackage

[sv/tick_alarm_compare_controller.sv]
`timescale 1ns / 1ps

// Alarm controller for a low-power tick timer. Each input beat is a command
// (start, set, stop, interrupt event or counter read) and yields exactly one
// result beat, held in a registered output. A new beat is accepted every
// cycle; the only stall is the single output register, so in_tready drops
// only while a result sits there and out_tready is low. The user must write
// period_top over the cfg port only while no beat is in flight; the block
// does not enforce this. It resets to 0xFFFF. time_extended joins the 16-bit
// overflow count (event-beat reload matches) above the low COUNTER_BITS bits.
module tick_alarm_compare_controller #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] alarm_time, [16] compare_written, [17] reload_match,
  // [18] compare_match, [34:19] counter_low, [39:35] zero
  input  logic [39:0] in_tdata,
  // [2:0] mode
  input  logic [2:0]  in_tuser,
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] write_compare, [16:1] compare_value, [17] fire_handler,
  // [49:18] time_extended, [50] alarm_is_active, [51] stop_must_wait, [55:52] zero
  output logic [55:0] out_tdata,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  tacc_pkg::state_t                state_r;
  tacc_pkg::state_t                state_nxt;
  tacc_pkg::item_t                 item;
  tacc_pkg::result_t               result;
  tacc_pkg::result_t               result_r;
  logic [tacc_pkg::TICK_W-1:0]     period_top_r;
  logic                            out_valid_r;
  logic                            in_beat;

  // beat unpacking
  assign item.mode            = in_tuser;
  assign item.alarm_time      = in_tdata[15:0];
  assign item.compare_written = in_tdata[16];
  assign item.reload_match    = in_tdata[17];
  assign item.compare_match   = in_tdata[18];
  assign item.counter_low     = in_tdata[34:19];

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign cfg_ready  = 1'b1;

  tacc_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .state     (state_r),
    .item      (item),
    .period_top(period_top_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      period_top_r <= tacc_pkg::PERIOD_TOP_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_beat) begin
        state_r <= state_nxt;
      end
      if (cfg_valid) begin
        period_top_r <= cfg_data;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      result_r <= result;
    end
  end

  assign out_tdata = {4'd0,
                      result_r.stop_must_wait,
                      result_r.alarm_is_active,
                      result_r.time_extended,
                      result_r.fire_handler,
                      result_r.compare_value,
                      result_r.write_compare};

`ifndef SYNTHESIS
  // a held update and an in-flight write never coexist
  a_held_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.update_held && state_r.write_in_flight))
    else $error("held update and write in flight both set");

  // a held update only exists for an armed alarm
  a_held_armed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.update_held |-> state_r.armed)
    else $error("held update while disarmed");

  // start arms and launches a compare write
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tuser == tacc_pkg::MODE_START) |=>
      (state_r.armed && state_r.write_in_flight && out_tvalid && out_tdata[0]))
    else $error("start did not arm and write");

  // stop disarms and reports disarmed
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tuser == tacc_pkg::MODE_STOP) |=> (!state_r.armed && !out_tdata[50]))
    else $error("stop left alarm armed");
`endif

endmodule

[sv/tacc_core.sv]
`timescale 1ns / 1ps

module tacc_core #(
  parameter int COUNTER_BITS = 16
) (
  input  tacc_pkg::state_t            state,
  input  tacc_pkg::item_t             item,
  input  logic [tacc_pkg::TICK_W-1:0] period_top,
  output tacc_pkg::state_t            state_nxt,
  output tacc_pkg::result_t           result
);

  localparam int unsigned WIDE_W = tacc_pkg::TICK_W + tacc_pkg::TIME_W;
  localparam logic [tacc_pkg::TICK_W-1:0] CNT_MASK =
    (COUNTER_BITS >= tacc_pkg::TICK_W) ? {tacc_pkg::TICK_W{1'b1}}
                                       : tacc_pkg::TICK_W'((1 << COUNTER_BITS) - 1);

  logic [WIDE_W-1:0] time_wide;

  // command decode and state update
  always_comb begin
    state_nxt = state;
    result    = '0;
    unique case (tacc_pkg::mode_t'(item.mode))
      tacc_pkg::MODE_START: begin
        state_nxt.alarm_value     = item.alarm_time;
        state_nxt.armed           = 1'b1;
        state_nxt.update_held     = 1'b0;
        state_nxt.write_in_flight = 1'b1;
        result.write_compare      = 1'b1;
        result.compare_value      = item.alarm_time;
      end
      tacc_pkg::MODE_SET: begin
        state_nxt.alarm_value = item.alarm_time;
        state_nxt.armed       = 1'b1;
        if (state.update_held || state.write_in_flight) begin
          // handshake busy: hold the new value until the write completes
          state_nxt.update_held     = 1'b1;
          state_nxt.write_in_flight = 1'b0;
        end else begin
          state_nxt.write_in_flight = 1'b1;
          result.write_compare      = 1'b1;
          result.compare_value      = item.alarm_time;
        end
      end
      tacc_pkg::MODE_STOP: begin
        result.stop_must_wait     = state.update_held || state.write_in_flight;
        state_nxt.alarm_value     = '0;
        state_nxt.armed           = 1'b0;
        state_nxt.update_held     = 1'b0;
        state_nxt.write_in_flight = 1'b0;
      end
      tacc_pkg::MODE_EVENT: begin
        // overflows count whether or not an alarm is armed
        if (item.reload_match) begin
          state_nxt.wrap_count = state.wrap_count + 1'b1;
        end
        if (state.armed) begin
          if (item.compare_written) begin
            if (state.update_held) begin
              result.write_compare      = 1'b1;
              result.compare_value      = state.alarm_value;
              state_nxt.update_held     = 1'b0;
              state_nxt.write_in_flight = 1'b1;
            end else begin
              state_nxt.write_in_flight = 1'b0;
            end
          end
          result.fire_handler = item.compare_match ||
                                (item.reload_match && state.alarm_value == period_top);
        end
      end
      default: begin
        // read and unused codes leave the state alone
      end
    endcase

    time_wide = (WIDE_W'(state_nxt.wrap_count) << COUNTER_BITS)
              | WIDE_W'(item.counter_low & CNT_MASK);
    result.time_extended   = time_wide[tacc_pkg::TIME_W-1:0];
    result.alarm_is_active = state_nxt.armed;
  end

endmodule
